@@ src/qec_pkg.sv @@
package qec_pkg;

  localparam int NUM_CHANNELS_DEF = 3;
  localparam int ACTION_W         = 2;
  localparam int CHANNEL_W        = 2;
  localparam int VALUE_W          = 32;
  localparam int RATE_W           = 16;
  localparam logic [RATE_W-1:0] RATE_RESET = 16'd1000;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_t;

  typedef struct packed {
    logic [ACTION_W-1:0]  action;
    logic [CHANNEL_W-1:0] channel;
    logic                 a_level;
    logic                 b_level;
  } in_item_t;

  typedef struct packed {
    logic [CHANNEL_W-1:0]      channel_out;
    logic signed [VALUE_W-1:0] position;
    logic signed [VALUE_W-1:0] speed;
    logic                      last;
  } out_item_t;

endpackage

@@ src/quadrature_encoder_counter.sv @@
// channel  direction  handshake             payload
// in_      input      in_valid / in_stall   qec_pkg::in_item_t
// out_     output     out_valid / out_stall qec_pkg::out_item_t
// cfg_     input      cfg_valid / cfg_ready cfg_data, update rate (16 bits)
//
// a sample or channel clear is taken one per cycle back to back while in_stall is low
// a tick is taken, then the single output register sends one result per channel,
// channel 0 first; in_stall is high while that drain runs
// rst_n is synchronous and clears all channel state, rate goes to 1000
// out_stall holds the output register and lengthens the tick drain to match
module quadrature_encoder_counter #(
  parameter int NUM_CHANNELS = qec_pkg::NUM_CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  qec_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output qec_pkg::out_item_t          out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [qec_pkg::RATE_W-1:0]  cfg_data
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int VW   = qec_pkg::VALUE_W;
  localparam logic [CH_W-1:0] LAST_IDX = CH_W'(NUM_CHANNELS - 1);

  logic [VW-1:0] delta_r [NUM_CHANNELS];
  logic [VW-1:0] delta_nxt [NUM_CHANNELS];
  logic [VW-1:0] count_r [NUM_CHANNELS];
  logic [VW-1:0] count_nxt [NUM_CHANNELS];
  logic [VW-1:0] vel_r [NUM_CHANNELS];
  logic [VW-1:0] vel_nxt [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] prev_a_r, prev_a_nxt;
  logic [NUM_CHANNELS-1:0] prev_b_r, prev_b_nxt;
  logic [qec_pkg::RATE_W-1:0] rate_r;

  logic            drain_act_r, drain_act_nxt;
  logic [CH_W-1:0] drain_idx_r, drain_idx_nxt;
  logic            out_vld_r, out_vld_nxt;
  qec_pkg::out_item_t out_data_r, out_data_nxt;

  logic in_acc;
  logic out_load;
  logic is_sample, is_tick, is_clear;

  assign in_stall  = drain_act_r;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  assign is_sample = in_acc && (in_data.action == qec_pkg::ACT_SAMPLE);
  assign is_tick   = in_acc && (in_data.action == qec_pkg::ACT_TICK);
  assign is_clear  = in_acc && (in_data.action == qec_pkg::ACT_CLEAR);

  always_comb begin
    logic       hit;
    logic [1:0] step;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      hit           = ({{(VW-qec_pkg::CHANNEL_W){1'b0}}, in_data.channel} == VW'(k));
      step          = 2'b00;
      delta_nxt[k]  = delta_r[k];
      count_nxt[k]  = count_r[k];
      vel_nxt[k]    = vel_r[k];
      prev_a_nxt[k] = prev_a_r[k];
      prev_b_nxt[k] = prev_b_r[k];
      if (is_sample && hit) begin
        step[0]       = (in_data.b_level != prev_a_r[k]);
        step[1]       = (in_data.a_level != prev_b_r[k]);
        case (step)
          2'b01:   delta_nxt[k] = delta_r[k] + VW'(1);
          2'b10:   delta_nxt[k] = delta_r[k] - VW'(1);
          default: delta_nxt[k] = delta_r[k];
        endcase
        prev_a_nxt[k] = in_data.a_level;
        prev_b_nxt[k] = in_data.b_level;
      end else if (is_tick) begin
        vel_nxt[k]   = delta_r[k] * {{(VW-qec_pkg::RATE_W){1'b0}}, rate_r};
        count_nxt[k] = count_r[k] + delta_r[k];
        delta_nxt[k] = '0;
      end else if (is_clear && hit) begin
        delta_nxt[k] = '0;
        count_nxt[k] = '0;
        vel_nxt[k]   = '0;
      end
    end
  end

  // result drain, one channel per cycle through the output register while out_stall does not hold it
  assign out_load = drain_act_r && (!out_vld_r || !out_stall);

  always_comb begin
    drain_act_nxt = drain_act_r;
    drain_idx_nxt = drain_idx_r;
    out_vld_nxt   = out_vld_r;
    out_data_nxt  = out_data_r;
    if (is_tick) begin
      drain_act_nxt = 1'b1;
      drain_idx_nxt = '0;
    end
    if (out_load) begin
      out_vld_nxt              = 1'b1;
      out_data_nxt.channel_out = qec_pkg::CHANNEL_W'(drain_idx_r);
      out_data_nxt.position    = count_r[drain_idx_r];
      out_data_nxt.speed       = vel_r[drain_idx_r];
      out_data_nxt.last        = (drain_idx_r == LAST_IDX);
      if (drain_idx_r == LAST_IDX) begin
        drain_act_nxt = 1'b0;
      end else begin
        drain_idx_nxt = drain_idx_r + CH_W'(1);
      end
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        delta_r[k] <= '0;
        count_r[k] <= '0;
        vel_r[k]   <= '0;
      end
      prev_a_r    <= '0;
      prev_b_r    <= '0;
      rate_r      <= qec_pkg::RATE_RESET;
      drain_act_r <= 1'b0;
      drain_idx_r <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        delta_r[k] <= delta_nxt[k];
        count_r[k] <= count_nxt[k];
        vel_r[k]   <= vel_nxt[k];
      end
      prev_a_r    <= prev_a_nxt;
      prev_b_r    <= prev_b_nxt;
      if (cfg_valid && cfg_ready) begin
        rate_r <= cfg_data;
      end
      drain_act_r <= drain_act_nxt;
      drain_idx_r <= drain_idx_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  a_tick_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    is_tick |=> drain_act_r && (drain_idx_r == '0))
    else $error("tick did not start result drain");

  a_last_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && (drain_idx_r == LAST_IDX) |=> !drain_act_r && out_vld_r && out_data_r.last)
    else $error("last result load did not end drain");

  a_drain_loads: assert property (@(posedge clk) disable iff (!rst_n)
    drain_act_r && !(out_vld_r && out_stall) |=> out_vld_r)
    else $error("drain step did not load output register");

  a_tick_clears_delta: assert property (@(posedge clk) disable iff (!rst_n)
    is_tick |=> (delta_r[0] == '0))
    else $error("tick did not clear period delta");

endmodule

@@ bench/quadrature_encoder_counter_tb.sv @@
`timescale 1ns / 1ps

module quadrature_encoder_counter_tb;

  localparam int NUM_CH = qec_pkg::NUM_CHANNELS_DEF;
  localparam int ACTION_W = qec_pkg::ACTION_W;
  localparam int CHANNEL_W = qec_pkg::CHANNEL_W;
  localparam int VALUE_W = qec_pkg::VALUE_W;
  localparam int RATE_W = qec_pkg::RATE_W;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [CHANNEL_W-1:0] CH_ABSENT = 2'd3;
  localparam int IDLE_PCT = 38;
  localparam int SETTLE_CYCLES = 4 * NUM_CH + 4;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  qec_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  qec_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [RATE_W-1:0] cfg_data = '0;

  qec_pkg::in_item_t encoder_events[$];
  qec_pkg::out_item_t expected_reports[$];

  logic [VALUE_W-1:0] model_delta [NUM_CH];
  logic [VALUE_W-1:0] model_count [NUM_CH];
  logic model_prev_a [NUM_CH];
  logic model_prev_b [NUM_CH];
  logic [RATE_W-1:0] model_rate = qec_pkg::RATE_RESET;

  logic gen_a [NUM_CH];
  logic gen_b [NUM_CH];

  bit no_idle = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  quadrature_encoder_counter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic advance_encoder_model(input qec_pkg::in_item_t it);
    qec_pkg::out_item_t rep;
    int k;
    case (it.action)
      qec_pkg::ACT_SAMPLE: begin
        if (it.channel < NUM_CH) begin
          if (it.b_level != model_prev_a[it.channel]) begin
            model_delta[it.channel] += 1;
          end
          if (it.a_level != model_prev_b[it.channel]) begin
            model_delta[it.channel] -= 1;
          end
          model_prev_a[it.channel] = it.a_level;
          model_prev_b[it.channel] = it.b_level;
        end
      end
      qec_pkg::ACT_TICK: begin
        for (k = 0; k < NUM_CH; k++) begin
          rep.speed = model_delta[k] * {16'd0, model_rate};
          model_count[k] += model_delta[k];
          model_delta[k] = '0;
          rep.channel_out = k[CHANNEL_W-1:0];
          rep.position = model_count[k];
          rep.last = (k == NUM_CH - 1);
          expected_reports.push_back(rep);
        end
      end
      qec_pkg::ACT_CLEAR: begin
        if (it.channel < NUM_CH) begin
          model_delta[it.channel] = '0;
          model_count[it.channel] = '0;
        end
      end
      default: begin
      end
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        advance_encoder_model(in_data);
      end
      if (!in_valid || !in_stall) begin
        if (encoder_events.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_data <= encoder_events.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_report(input qec_pkg::out_item_t got);
    qec_pkg::out_item_t want;
    if (expected_reports.size() == 0) begin
      $error("unexpected result transaction: channel_out %0d", got.channel_out);
      mismatches++;
    end else begin
      want = expected_reports.pop_front();
      if (got.channel_out !== want.channel_out) begin
        $error("channel_out: expected %0d, got %0d", want.channel_out, got.channel_out);
        mismatches++;
      end
      if (got.position !== want.position) begin
        $error("position: expected %0d, got %0d", want.position, got.position);
        mismatches++;
      end
      if (got.speed !== want.speed) begin
        $error("speed: expected %0d, got %0d", want.speed, got.speed);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
    end
  endtask

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      check_report(out_data);
    end
    out_stall <= rst_n && !no_idle && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic queue_item(input logic [ACTION_W-1:0] act, input logic [CHANNEL_W-1:0] ch,
                            input logic a, input logic b);
    qec_pkg::in_item_t it;
    it.action = act;
    it.channel = ch;
    it.a_level = a;
    it.b_level = b;
    encoder_events.push_back(it);
    if (act == qec_pkg::ACT_SAMPLE && ch < NUM_CH) begin
      gen_a[ch] = a;
      gen_b[ch] = b;
    end
  endtask

  // random channel and levels, any action code
  task automatic queue_random_fields(input logic [ACTION_W-1:0] act);
    queue_item(act, CHANNEL_W'($urandom_range(3)), 1'($urandom_range(1)),
               1'($urandom_range(1)));
  endtask

  // one gray-code step along the quadrature cycle
  task automatic queue_step(input int ch, input bit forward);
    if (forward) begin
      queue_item(qec_pkg::ACT_SAMPLE, ch[CHANNEL_W-1:0], gen_b[ch], ~gen_a[ch]);
    end else begin
      queue_item(qec_pkg::ACT_SAMPLE, ch[CHANNEL_W-1:0], ~gen_b[ch], gen_a[ch]);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (encoder_events.size() != 0 || in_valid || expected_reports.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_update_rate(input logic [RATE_W-1:0] rate);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= rate;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    model_rate = rate;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_random_items(input int count);
    int n;
    int r;
    int ch;
    int fwd_pct;
    fwd_pct = $urandom_range(90, 10);
    for (n = 0; n < count; n++) begin
      r = $urandom_range(99);
      ch = $urandom_range(NUM_CH - 1);
      if (r < 70) begin
        queue_step(ch, $urandom_range(99) < fwd_pct);
      end else if (r < 80) begin
        queue_random_fields(qec_pkg::ACT_TICK);
      end else if (r < 86) begin
        queue_random_fields(qec_pkg::ACT_CLEAR);
      end else if (r < 94) begin
        queue_random_fields(qec_pkg::ACT_SAMPLE);
      end else begin
        queue_random_fields(ACT_UNUSED);
      end
    end
    queue_item(qec_pkg::ACT_TICK, '0, 1'b0, 1'b0);
  endtask

  initial begin
    int k;
    for (k = 0; k < NUM_CH; k++) begin
      model_delta[k] = '0;
      model_count[k] = '0;
      model_prev_a[k] = 1'b0;
      model_prev_b[k] = 1'b0;
      gen_a[k] = 1'b0;
      gen_b[k] = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, at the reset rate
    queue_item(qec_pkg::ACT_TICK, '0, 1'b0, 1'b0);
    queue_step(0, 1'b1);
    queue_step(0, 1'b1);
    queue_step(0, 1'b1);
    queue_step(0, 1'b1);
    queue_step(1, 1'b0);
    queue_step(1, 1'b0);
    // both phases flip, no net count
    queue_item(qec_pkg::ACT_SAMPLE, 2'd2, 1'b1, 1'b1);
    queue_item(qec_pkg::ACT_SAMPLE, 2'd2, 1'b0, 1'b0);
    queue_item(qec_pkg::ACT_SAMPLE, CH_ABSENT, 1'b1, 1'b0);
    queue_item(ACT_UNUSED, 2'd0, 1'b1, 1'b1);
    queue_item(qec_pkg::ACT_TICK, CH_ABSENT, 1'b1, 1'b1);
    queue_item(qec_pkg::ACT_CLEAR, 2'd0, 1'b0, 1'b0);
    queue_item(qec_pkg::ACT_CLEAR, CH_ABSENT, 1'b1, 1'b1);
    queue_step(1, 1'b0);
    queue_step(0, 1'b0);
    queue_item(qec_pkg::ACT_TICK, 2'd0, 1'b0, 1'b0);
    wait_idle();

    write_update_rate(16'hFFFF);
    queue_random_items(25);
    wait_idle();
    queue_random_items(25);
    wait_idle();

    write_update_rate(16'd0);
    no_idle = 1'b1;
    queue_random_items(35);
    wait_idle();
    no_idle = 1'b0;

    write_update_rate(16'd1);
    queue_random_items(45);
    wait_idle();

    write_update_rate(RATE_W'($urandom_range(16'hFFFF)));
    queue_random_items(30);
    wait_idle();

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
